@@ sv/fwdf_pkg.sv @@
package fwdf_pkg;

  localparam int MAX_DIGITS = 10;
  localparam int POS_W      = $clog2(MAX_DIGITS + 1);
  localparam int VAL_W      = 32;
  localparam int DIV_W      = 30;                 // 10^9 fits in 30 bits
  localparam int LONG_STEPS  = VAL_W;
  localparam int SHORT_STEPS = 4;                 // later digits are below ten
  localparam int STEP_W     = $clog2(LONG_STEPS + 1);

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_NONE = 8'h00;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [7:0]       digit_count;
  } req_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
    logic       status;
    logic       overflow;
  } rsp_t;

  typedef struct packed {
    logic start;
    logic long_mode;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [DIV_W-1:0] pow10(input logic [POS_W-1:0] e);
    logic [DIV_W-1:0] p;
    case (e)
      4'd0:    p = DIV_W'(1);
      4'd1:    p = DIV_W'(10);
      4'd2:    p = DIV_W'(100);
      4'd3:    p = DIV_W'(1000);
      4'd4:    p = DIV_W'(10000);
      4'd5:    p = DIV_W'(100000);
      4'd6:    p = DIV_W'(1000000);
      4'd7:    p = DIV_W'(10000000);
      4'd8:    p = DIV_W'(100000000);
      4'd9:    p = DIV_W'(1000000000);
      default: p = DIV_W'(1);
    endcase
    return p;
  endfunction

endpackage

@@ sv/fixed_width_decimal_formatter.sv @@
// after acceptance each digit is written once its division is done and the output register is free,
//   the leading digit from a long division and each later digit from a short one, then line feed and carriage return
// one number at a time; the shared restoring divider (one bit per cycle while busy,
//   32 steps for the leading digit, 4 for the rest) computes every digit
// a bad digit count gives its single error word instead of any digits
// reset (rst, synchronous, active high) empties the output register and idles the sequencer
module fixed_width_decimal_formatter import fwdf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  // sequencer codes
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_PUT   = 3'd3;
  localparam logic [2:0] ST_LF    = 3'd4;
  localparam logic [2:0] ST_CR    = 3'd5;
  localparam logic [2:0] ST_ERR   = 3'd6;

  logic [2:0]       state;
  logic [POS_W-1:0] pos;     // digits still to emit
  logic [VAL_W-1:0] rem;     // running remainder
  logic             first;   // leading digit may be wide

  div_ctrl_t        div_ctrl;
  div_stat_t        div_stat;
  logic [VAL_W-1:0] div_quo;
  logic [VAL_W-1:0] div_rem;

  logic req_take;
  logic slot_free;
  logic count_ok;
  logic wr_en;
  rsp_t wr_word;

  assign req_stall = (state != ST_IDLE);
  assign req_take  = req_valid && !req_stall;
  // output register takes a new word when empty or drained this cycle
  assign slot_free = !rsp_valid || !rsp_stall;
  assign count_ok  = (req.digit_count >= 8'd1) && (req.digit_count <= 8'(MAX_DIGITS));

  assign div_ctrl.start     = (state == ST_START);
  assign div_ctrl.long_mode = first;

  fwdf_div u_div (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (div_ctrl),
    .dividend  (rem),
    .divisor   (pow10(pos - POS_W'(1))),
    .stat      (div_stat),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // word to load into the output register
  always_comb begin
    wr_en   = 1'b0;
    wr_word = '0;
    unique case (state) inside
      ST_PUT: begin
        wr_en              = slot_free;
        wr_word.char_code  = CH_ZERO + div_quo[7:0];   // wraps as an 8-bit code
        wr_word.status     = STATUS_OK;
        wr_word.overflow   = (|div_quo[VAL_W-1:4]) || (div_quo[3:0] > 4'd9);
      end
      ST_LF: begin
        wr_en             = slot_free;
        wr_word.char_code = CH_LF;
        wr_word.status    = STATUS_OK;
      end
      ST_CR: begin
        wr_en             = slot_free;
        wr_word.char_code = CH_CR;
        wr_word.last      = 1'b1;
        wr_word.status    = STATUS_OK;
      end
      ST_ERR: begin
        wr_en             = slot_free;
        wr_word.char_code = CH_NONE;
        wr_word.last      = 1'b1;
        wr_word.status    = STATUS_ERR;
      end
      ST_IDLE, ST_START, ST_DIV: begin
        wr_en = 1'b0;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      first <= 1'b0;
      pos   <= '0;
    end else begin
      unique case (state) inside
        ST_IDLE: begin
          if (req_take) begin
            pos   <= req.digit_count[POS_W-1:0];
            first <= 1'b1;
            state <= count_ok ? ST_START : ST_ERR;
          end
        end
        ST_START: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_stat.done) begin
            state <= ST_PUT;
          end
        end
        ST_PUT: begin
          if (slot_free) begin
            first <= 1'b0;
            pos   <= pos - POS_W'(1);
            state <= (pos == POS_W'(1)) ? ST_LF : ST_START;
          end
        end
        ST_LF: begin
          if (slot_free) begin
            state <= ST_CR;
          end
        end
        ST_CR, ST_ERR: begin
          if (slot_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // remainder carried from one digit to the next
  always_ff @(posedge clk) begin
    if (req_take) begin
      rem <= req.value;
    end else if (state == ST_PUT && slot_free) begin
      rem <= div_rem;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (wr_en) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rsp <= wr_word;
    end
  end

  // divider is never restarted mid-division
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_ctrl.start |-> !div_stat.busy)
    else $error("divider started while busy");

  // a digit is only emitted from a finished division
  a_put_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PUT) |-> !div_stat.busy)
    else $error("digit taken from a running division");

  // overflow only on digit words
  a_ovf_digit: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.overflow) |-> (!rsp.last && rsp.status == STATUS_OK))
    else $error("overflow outside a digit word");

  // an error word stands alone and carries no character
  a_err_word: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status == STATUS_ERR) |-> (rsp.last && rsp.char_code == CH_NONE))
    else $error("malformed error word");

endmodule

@@ sv/fwdf_div.sv @@
module fwdf_div import fwdf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  div_ctrl_t        ctrl,
  input  logic [VAL_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output div_stat_t        stat,
  output logic [VAL_W-1:0] quotient,
  output logic [VAL_W-1:0] remainder
);

  logic [VAL_W:0]    part;
  logic [VAL_W-1:0]  quo;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic              done;

  logic [VAL_W:0] shifted;
  logic           fits;

  // one restoring step per cycle while busy
  assign shifted = {part[VAL_W-1:0], quo[VAL_W-1]};
  assign fits    = shifted >= {{(VAL_W+1-DIV_W){1'b0}}, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        if (ctrl.long_mode) begin
          steps <= STEP_W'(LONG_STEPS);
        end else begin
          steps <= STEP_W'(SHORT_STEPS);
        end
      end else if (busy) begin
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      if (ctrl.long_mode) begin
        part <= '0;
        quo  <= dividend;
      end else begin
        // partial remainder already below the divisor, quotient fits 4 bits
        part <= {{(SHORT_STEPS+1){1'b0}}, dividend[VAL_W-1:SHORT_STEPS]};
        quo  <= {dividend[SHORT_STEPS-1:0], {(VAL_W-SHORT_STEPS){1'b0}}};
      end
    end else if (busy) begin
      part <= fits ? (shifted - {{(VAL_W+1-DIV_W){1'b0}}, divisor}) : shifted;
      quo  <= {quo[VAL_W-2:0], fits};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;
  assign remainder = part[VAL_W-1:0];

endmodule
